[hdl/ghp_pkg.sv]
// ----------------------------------------------------------------------------
// ghp_pkg
// Shared types, constants and the element size table of the header parser.
// ----------------------------------------------------------------------------
package ghp_pkg;

   localparam int MAX_KV_ENTRIES_DEF     = 256;
   localparam int MAX_TENSOR_ENTRIES_DEF = 1024;
   localparam int KEY_NAME_LEN_DEF       = 64;
   localparam int TENSOR_NAME_LEN_DEF    = 64;
   localparam int MAX_DIMS_DEF           = 4;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAGIC       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERSION_MIN = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERSION_MAX = 2'd2;

   localparam logic [31:0] MAGIC_RESET       = 32'h4655_4747;
   localparam logic [31:0] VERSION_MIN_RESET = 32'd2;
   localparam logic [31:0] VERSION_MAX_RESET = 32'd3;

   localparam logic [2:0] KIND_COUNTS = 3'd0;
   localparam logic [2:0] KIND_NAME   = 3'd1;
   localparam logic [2:0] KIND_KV     = 3'd2;
   localparam logic [2:0] KIND_TENSOR = 3'd3;
   localparam logic [2:0] KIND_DONE   = 3'd4;
   localparam logic [2:0] KIND_ERROR  = 3'd5;

   localparam logic [3:0] NAME_KEY    = 4'd0;
   localparam logic [3:0] NAME_TENSOR = 4'd1;

   localparam logic [63:0] ERR_TRUNCATED   = 64'd1;
   localparam logic [63:0] ERR_BAD_MAGIC   = 64'd2;
   localparam logic [63:0] ERR_BAD_VERSION = 64'd3;
   localparam logic [63:0] ERR_TOO_MANY    = 64'd4;
   localparam logic [63:0] ERR_BAD_TYPE    = 64'd5;

   localparam logic [31:0] TYPE_STRING = 32'd8;
   localparam logic [31:0] TYPE_ARRAY  = 32'd9;
   localparam logic [31:0] TYPE_LAST   = 32'd12;

   typedef struct packed {
      logic [2:0]       kind;
      logic [9:0]       entry;
      logic [3:0]       vtype;
      logic [63:0]      vword;
      logic [31:0]      arr_etype;
      logic [31:0]      dim_count;
      logic [3:0][63:0] dims;
      logic [63:0]      offset;
   } rec_type;

   typedef struct packed {
      rec_type     rec0;
      logic        has1;
      logic [2:0]  kind1;
      logic [9:0]  entry1;
      logic [63:0] offset1;
   } slot_type;

   function automatic logic [3:0] elem_size(input logic [31:0] code);
      logic [3:0] sz;
      case (code)
         32'd0, 32'd1, 32'd7:    sz = 4'd1;
         32'd2, 32'd3:           sz = 4'd2;
         32'd4, 32'd5, 32'd6:    sz = 4'd4;
         32'd8, 32'd9:           sz = 4'd0;
         32'd10, 32'd11, 32'd12: sz = 4'd8;
         default:                sz = 4'd4;
      endcase
      return sz;
   endfunction

endpackage

[hdl/ghp_front.sv]
// ----------------------------------------------------------------------------
// ghp_front
// Byte parser: consumes one header byte per cycle while the queue is not full and builds record slots.
// ----------------------------------------------------------------------------
module ghp_front #(
   parameter int MAX_KV_ENTRIES     = ghp_pkg::MAX_KV_ENTRIES_DEF,
   parameter int MAX_TENSOR_ENTRIES = ghp_pkg::MAX_TENSOR_ENTRIES_DEF,
   parameter int KEY_NAME_LEN       = ghp_pkg::KEY_NAME_LEN_DEF,
   parameter int TENSOR_NAME_LEN    = ghp_pkg::TENSOR_NAME_LEN_DEF,
   parameter int MAX_DIMS           = ghp_pkg::MAX_DIMS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [ghp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [31:0]                      csr_wdata,
   input  logic                             in_valid,
   input  logic [7:0]                       in_byte,
   input  logic                             in_last,
   output logic                             in_ready,
   input  logic                             q_full,
   output logic                             push,
   output ghp_pkg::slot_type                push_data
);

   localparam logic [4:0] PH_MAGIC      = 5'd0;
   localparam logic [4:0] PH_VERSION    = 5'd1;
   localparam logic [4:0] PH_NTENS      = 5'd2;
   localparam logic [4:0] PH_NKV        = 5'd3;
   localparam logic [4:0] PH_KEYLEN     = 5'd4;
   localparam logic [4:0] PH_KEYCHARS   = 5'd5;
   localparam logic [4:0] PH_VTYPE      = 5'd6;
   localparam logic [4:0] PH_SCALAR     = 5'd7;
   localparam logic [4:0] PH_STRLEN     = 5'd8;
   localparam logic [4:0] PH_STRDATA    = 5'd9;
   localparam logic [4:0] PH_ARRTYPE    = 5'd10;
   localparam logic [4:0] PH_ARRCOUNT   = 5'd11;
   localparam logic [4:0] PH_ARRSKIP    = 5'd12;
   localparam logic [4:0] PH_ELEMLEN    = 5'd13;
   localparam logic [4:0] PH_ELEMDATA   = 5'd14;
   localparam logic [4:0] PH_TNAMELEN   = 5'd15;
   localparam logic [4:0] PH_TNAMECHARS = 5'd16;
   localparam logic [4:0] PH_NDIMS      = 5'd17;
   localparam logic [4:0] PH_DIM        = 5'd18;
   localparam logic [4:0] PH_TTYPE      = 5'd19;
   localparam logic [4:0] PH_TOFF       = 5'd20;

   localparam logic [7:0] KEY_LIMIT = 8'(KEY_NAME_LEN - 1);
   localparam logic [7:0] TNAME_LIMIT = 8'(TENSOR_NAME_LEN - 1);

   logic [31:0] magic_ff, magic_in, vmin_ff, vmin_in, vmax_ff, vmax_in;
   logic [4:0]  phase_ff, phase_in;
   logic [3:0]  fbc_ff, fbc_in;
   logic [63:0] fshift_ff, fshift_in, skip_ff, skip_in, arr_ff, arr_in;
   logic [63:0] kv_ff, kv_in, ten_ff, ten_in, bpos_ff, bpos_in;
   logic [9:0]  entry_ff, entry_in;
   logic [35:0] ctypes_ff, ctypes_in;
   logic [3:0][63:0] dims_ff, dims_in;
   logic [31:0] dl_ff, dl_in, tt_ff, tt_in;
   logic [7:0]  name_ff, name_in;
   logic        fin_ff, fin_in;

   logic        take, gdone, bskip, skd, nelem, nkv, st, emit, err1;
   logic [3:0]  gw, cnt1, esz;
   logic [63:0] shifted, v, bn, total;
   logic [4:0]  bph, skph;
   logic [31:0] didx;
   ghp_pkg::rec_type prim, second;
   logic        prim_v;

   assign in_ready = !q_full;
   assign take = in_valid && !q_full;

   always_comb begin
      magic_in = magic_ff; vmin_in = vmin_ff; vmax_in = vmax_ff;
      if (csr_we) begin
         case (csr_index)
            ghp_pkg::CSR_MAGIC:       magic_in = csr_wdata;
            ghp_pkg::CSR_VERSION_MIN: vmin_in = csr_wdata;
            ghp_pkg::CSR_VERSION_MAX: vmax_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (phase_ff)
         PH_MAGIC, PH_VERSION, PH_VTYPE, PH_ARRTYPE, PH_NDIMS, PH_TTYPE: gw = 4'd4;
         PH_NTENS, PH_NKV, PH_KEYLEN, PH_STRLEN, PH_ARRCOUNT, PH_ELEMLEN,
         PH_TNAMELEN, PH_DIM, PH_TOFF: gw = 4'd8;
         PH_SCALAR: gw = ghp_pkg::elem_size({28'd0, ctypes_ff[35:32]});
         default: gw = 4'd0;
      endcase
   end

   assign shifted = fshift_ff | ({56'd0, in_byte} << {fbc_ff[2:0], 3'b000});
   assign cnt1 = fbc_ff + 4'd1;
   assign v = shifted;
   assign esz = ghp_pkg::elem_size(ctypes_ff[31:0]);
   assign didx = ctypes_ff[31:0] - dl_ff;

   always_comb begin
      case (esz)
         4'd1:    total = v;
         4'd2:    total = v[63] ? '1 : {v[62:0], 1'b0};
         4'd4:    total = (|v[63:62]) ? '1 : {v[61:0], 2'b00};
         4'd8:    total = (|v[63:61]) ? '1 : {v[60:0], 3'b000};
         default: total = '0;
      endcase
   end

   always_comb begin
      phase_in = phase_ff; fbc_in = fbc_ff; fshift_in = fshift_ff;
      skip_in = skip_ff; arr_in = arr_ff; kv_in = kv_ff; ten_in = ten_ff;
      bpos_in = bpos_ff; entry_in = entry_ff; ctypes_in = ctypes_ff;
      dims_in = dims_ff; dl_in = dl_ff; tt_in = tt_ff; name_in = name_ff;
      fin_in = fin_ff;
      gdone = 1'b0; bskip = 1'b0; bph = PH_MAGIC; bn = '0;
      skd = 1'b0; skph = PH_MAGIC; nelem = 1'b0; nkv = 1'b0; st = 1'b0;
      emit = 1'b0; err1 = 1'b0;
      prim_v = 1'b0; prim = '0; second = '0;
      push = 1'b0; push_data = '0;
      if (take) begin
         if (!fin_ff) begin
            bpos_in = bpos_ff + 64'd1;
            if (gw != 4'd0) begin
               if (cnt1 >= gw) begin
                  gdone = 1'b1; fbc_in = '0; fshift_in = '0;
               end else begin
                  fbc_in = cnt1; fshift_in = shifted;
               end
            end
            prim.entry = entry_ff;
            case (phase_ff)
               PH_MAGIC: if (gdone) begin
                  if (v[31:0] != magic_ff) begin
                     prim_v = 1'b1; prim.kind = ghp_pkg::KIND_ERROR;
                     prim.vword = ghp_pkg::ERR_BAD_MAGIC; fin_in = 1'b1;
                  end else phase_in = PH_VERSION;
               end
               PH_VERSION: if (gdone) begin
                  if (v[31:0] < vmin_ff || v[31:0] > vmax_ff) begin
                     prim_v = 1'b1; prim.kind = ghp_pkg::KIND_ERROR;
                     prim.vword = ghp_pkg::ERR_BAD_VERSION; fin_in = 1'b1;
                  end else phase_in = PH_NTENS;
               end
               PH_NTENS: if (gdone) begin
                  ten_in = v; phase_in = PH_NKV;
               end
               PH_NKV: if (gdone) begin
                  kv_in = v;
                  prim_v = 1'b1;
                  if (v > 64'(MAX_KV_ENTRIES) || ten_ff > 64'(MAX_TENSOR_ENTRIES)) begin
                     prim.kind = ghp_pkg::KIND_ERROR;
                     prim.vword = ghp_pkg::ERR_TOO_MANY; fin_in = 1'b1;
                  end else begin
                     entry_in = '0;
                     prim.kind = ghp_pkg::KIND_COUNTS; prim.entry = '0;
                     prim.vword = v; prim.offset = ten_ff;
                     if (v != '0) phase_in = PH_KEYLEN;
                     else st = 1'b1;
                  end
               end
               PH_KEYLEN: if (gdone) begin
                  name_in = '0; bskip = 1'b1; bph = PH_KEYCHARS; bn = v;
               end
               PH_VTYPE: if (gdone) begin
                  if (v[31:0] > ghp_pkg::TYPE_LAST) begin
                     prim_v = 1'b1; prim.kind = ghp_pkg::KIND_ERROR;
                     prim.vword = ghp_pkg::ERR_BAD_TYPE; fin_in = 1'b1;
                  end else begin
                     ctypes_in = {v[3:0], 32'd0};
                     if (v[31:0] == ghp_pkg::TYPE_STRING) phase_in = PH_STRLEN;
                     else if (v[31:0] == ghp_pkg::TYPE_ARRAY) phase_in = PH_ARRTYPE;
                     else phase_in = PH_SCALAR;
                  end
               end
               PH_SCALAR: if (gdone) begin
                  prim_v = 1'b1; prim.kind = ghp_pkg::KIND_KV;
                  prim.vtype = ctypes_ff[35:32]; prim.vword = v; nkv = 1'b1;
               end
               PH_STRLEN: if (gdone) begin
                  prim_v = 1'b1; prim.kind = ghp_pkg::KIND_KV;
                  prim.vtype = ghp_pkg::TYPE_STRING[3:0]; prim.vword = v;
                  prim.offset = bpos_in;
                  bskip = 1'b1; bph = PH_STRDATA; bn = v;
               end
               PH_ARRTYPE: if (gdone) begin
                  ctypes_in = {ghp_pkg::TYPE_ARRAY[3:0], v[31:0]};
                  phase_in = PH_ARRCOUNT;
               end
               PH_ARRCOUNT: if (gdone) begin
                  prim_v = 1'b1; prim.kind = ghp_pkg::KIND_KV;
                  prim.vtype = ghp_pkg::TYPE_ARRAY[3:0]; prim.vword = v;
                  prim.arr_etype = ctypes_ff[31:0]; prim.offset = bpos_in;
                  if (ctypes_ff[31:0] == ghp_pkg::TYPE_STRING) begin
                     if (v != '0) begin
                        arr_in = v; phase_in = PH_ELEMLEN;
                     end else nkv = 1'b1;
                  end else begin
                     bskip = 1'b1; bph = PH_ARRSKIP; bn = total;
                  end
               end
               PH_ELEMLEN: if (gdone) begin
                  bskip = 1'b1; bph = PH_ELEMDATA; bn = v;
               end
               PH_TNAMELEN: if (gdone) begin
                  dims_in = '0; name_in = '0;
                  bskip = 1'b1; bph = PH_TNAMECHARS; bn = v;
               end
               PH_KEYCHARS, PH_TNAMECHARS: begin
                  if (name_ff < ((phase_ff == PH_KEYCHARS) ? KEY_LIMIT : TNAME_LIMIT)) begin
                     prim_v = 1'b1; prim.kind = ghp_pkg::KIND_NAME;
                     prim.vtype = (phase_ff == PH_KEYCHARS) ? ghp_pkg::NAME_KEY
                                                            : ghp_pkg::NAME_TENSOR;
                     prim.vword = {56'd0, in_byte};
                     name_in = name_ff + 8'd1;
                  end
                  skip_in = skip_ff - 64'd1;
                  if (skip_in == '0) begin
                     skd = 1'b1; skph = phase_ff;
                  end
               end
               PH_NDIMS: if (gdone) begin
                  ctypes_in = {4'd0, v[31:0]}; dl_in = v[31:0];
                  phase_in = (v[31:0] != '0) ? PH_DIM : PH_TTYPE;
               end
               PH_DIM: if (gdone) begin
                  if (didx < 32'(MAX_DIMS)) dims_in[didx[1:0]] = v;
                  dl_in = dl_ff - 32'd1;
                  if (dl_in == '0) phase_in = PH_TTYPE;
               end
               PH_TTYPE: if (gdone) begin
                  tt_in = v[31:0]; phase_in = PH_TOFF;
               end
               PH_TOFF: if (gdone) begin
                  prim_v = 1'b1; prim.kind = ghp_pkg::KIND_TENSOR;
                  prim.vword = {32'd0, tt_ff}; prim.dim_count = ctypes_ff[31:0];
                  prim.dims = dims_ff; prim.offset = v;
                  ten_in = ten_ff - 64'd1;
                  entry_in = entry_ff + 10'd1;
                  if (ten_in != '0) phase_in = PH_TNAMELEN;
                  else emit = 1'b1;
               end
               default: begin
                  skip_in = skip_ff - 64'd1;
                  if (skip_in == '0) begin
                     skd = 1'b1; skph = phase_ff;
                  end
               end
            endcase
            if (bskip) begin
               if (bn == '0) begin
                  skd = 1'b1; skph = bph;
               end else begin
                  phase_in = bph; skip_in = bn;
               end
            end
            if (skd) begin
               case (skph)
                  PH_KEYCHARS:   phase_in = PH_VTYPE;
                  PH_ELEMDATA:   nelem = 1'b1;
                  PH_TNAMECHARS: phase_in = PH_NDIMS;
                  default:       nkv = 1'b1;
               endcase
            end
            if (nelem) begin
               arr_in = arr_in - 64'd1;
               if (arr_in != '0) phase_in = PH_ELEMLEN;
               else nkv = 1'b1;
            end
            if (nkv) begin
               kv_in = kv_in - 64'd1;
               entry_in = entry_in + 10'd1;
               if (kv_in != '0) phase_in = PH_KEYLEN;
               else st = 1'b1;
            end
            if (st) begin
               entry_in = '0;
               if (ten_in != '0) phase_in = PH_TNAMELEN;
               else emit = 1'b1;
            end
            if (emit) fin_in = 1'b1;
         end
         if (emit) begin
            second.kind = ghp_pkg::KIND_DONE;
            second.offset = (bpos_in + 64'd31) & ~64'd31;
         end
         if (in_last) begin
            if (!fin_in) begin
               err1 = 1'b1;
               second.kind = ghp_pkg::KIND_ERROR;
               second.entry = entry_in;
               second.vword = ghp_pkg::ERR_TRUNCATED;
            end
            phase_in = PH_MAGIC; fbc_in = '0; fshift_in = '0; skip_in = '0;
            arr_in = '0; kv_in = '0; ten_in = '0; entry_in = '0; bpos_in = '0;
            ctypes_in = '0; dims_in = '0; dl_in = '0; name_in = '0; tt_in = '0;
            fin_in = 1'b0;
         end
         push = prim_v || emit || err1;
         if (prim_v) begin
            push_data.rec0 = prim;
            push_data.has1 = emit || err1;
            push_data.kind1 = second.kind;
            push_data.entry1 = second.entry;
            push_data.offset1 = second.offset;
         end else begin
            push_data.rec0 = second;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff <= ghp_pkg::MAGIC_RESET;
         vmin_ff <= ghp_pkg::VERSION_MIN_RESET;
         vmax_ff <= ghp_pkg::VERSION_MAX_RESET;
         phase_ff <= PH_MAGIC; fbc_ff <= '0; fshift_ff <= '0; skip_ff <= '0;
         arr_ff <= '0; kv_ff <= '0; ten_ff <= '0; bpos_ff <= '0; entry_ff <= '0;
         ctypes_ff <= '0; dims_ff <= '0; dl_ff <= '0; tt_ff <= '0; name_ff <= '0;
         fin_ff <= 1'b0;
      end else begin
         magic_ff <= magic_in; vmin_ff <= vmin_in; vmax_ff <= vmax_in;
         phase_ff <= phase_in; fbc_ff <= fbc_in; fshift_ff <= fshift_in;
         skip_ff <= skip_in; arr_ff <= arr_in; kv_ff <= kv_in; ten_ff <= ten_in;
         bpos_ff <= bpos_in; entry_ff <= entry_in; ctypes_ff <= ctypes_in;
         dims_ff <= dims_in; dl_ff <= dl_in; tt_ff <= tt_in; name_ff <= name_in;
         fin_ff <= fin_in;
      end
   end

endmodule

[hdl/ghp_queue.sv]
// ----------------------------------------------------------------------------
// ghp_queue
// Short slot queue between the parser and the record sender.
// ----------------------------------------------------------------------------
module ghp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ghp_pkg::slot_type push_data,
   output logic              full,
   input  logic              pop,
   output ghp_pkg::slot_type head,
   output logic              empty
);

   ghp_pkg::slot_type mem_ff [ghp_pkg::QUEUE_DEPTH];
   logic [ghp_pkg::QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [ghp_pkg::QPTR_W:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == (ghp_pkg::QPTR_W+1)'(ghp_pkg::QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ff];

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (ghp_pkg::QPTR_W+1)'(push) - (ghp_pkg::QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("pop from empty queue");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count lost a push");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      wr_ff == rd_ff + cnt_ff[ghp_pkg::QPTR_W-1:0])
      else $error("queue pointers disagree with count");
`endif

endmodule

[hdl/ghp_back.sv]
// ----------------------------------------------------------------------------
// ghp_back
// Record sender: unpacks each queued slot into one or two result records.
// ----------------------------------------------------------------------------
module ghp_back (
   input  logic              clock,
   input  logic              reset,
   input  ghp_pkg::slot_type head,
   input  logic              empty,
   output logic              pop,
   output logic              out_valid,
   input  logic              out_ready,
   output ghp_pkg::rec_type  out_rec,
   output logic              out_last
);

   logic sel_ff, sel_in, fire;

   assign out_valid = !empty;
   assign out_last  = sel_ff || !head.has1;
   assign fire      = out_valid && out_ready;
   assign pop       = fire && out_last;

   always_comb begin
      out_rec = head.rec0;
      if (sel_ff) begin
         out_rec = '0;
         out_rec.kind = head.kind1;
         out_rec.entry = head.entry1;
         out_rec.offset = head.offset1;
         out_rec.vword = (head.kind1 == ghp_pkg::KIND_ERROR) ? ghp_pkg::ERR_TRUNCATED : '0;
      end
      sel_in = sel_ff;
      if (fire) sel_in = !out_last;
   end

   always_ff @(posedge clock) begin
      if (reset) sel_ff <= 1'b0;
      else sel_ff <= sel_in;
   end

endmodule

[hdl/gguf_header_stream_parser.sv]
// ----------------------------------------------------------------------------
// gguf_header_stream_parser
// Byte-serial model file header parser with a record stream output.
// ----------------------------------------------------------------------------
// One header byte is taken per cycle (req_tlast ends a buffer; the next byte
// starts a new parse). Each byte yields zero, one or two records; the parser
// runs ahead of the sender through a four-slot queue, so input stalls only when
// that queue is full. The sender gives one record per cycle while rsp_tready is high, so sustained rate
// is one byte per cycle while records average no more than one per byte.
module gguf_header_stream_parser #(
   parameter int MAX_KV_ENTRIES     = ghp_pkg::MAX_KV_ENTRIES_DEF,
   parameter int MAX_TENSOR_ENTRIES = ghp_pkg::MAX_TENSOR_ENTRIES_DEF,
   parameter int KEY_NAME_LEN       = ghp_pkg::KEY_NAME_LEN_DEF,
   parameter int TENSOR_NAME_LEN    = ghp_pkg::TENSOR_NAME_LEN_DEF,
   parameter int MAX_DIMS           = ghp_pkg::MAX_DIMS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [ghp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                     csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // data_byte
   input  logic                            req_tlast,   // end_of_buffer
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // entry_index, value_type, value_word, array_elem_type, dim_count,
   // dim_zero, dim_one, dim_two, dim_three, offset_word, pad
   output logic [463:0]                    rsp_tdata,
   output logic [2:0]                      rsp_tuser,   // rec_kind
   output logic                            rsp_tlast    // run_last
);

   logic              push, q_full, pop, q_empty;
   ghp_pkg::slot_type push_data, head;
   ghp_pkg::rec_type  rec;

   ghp_front #(
      .MAX_KV_ENTRIES(MAX_KV_ENTRIES), .MAX_TENSOR_ENTRIES(MAX_TENSOR_ENTRIES),
      .KEY_NAME_LEN(KEY_NAME_LEN), .TENSOR_NAME_LEN(TENSOR_NAME_LEN),
      .MAX_DIMS(MAX_DIMS)
   ) u_front (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .in_valid(req_tvalid), .in_byte(req_tdata), .in_last(req_tlast),
      .in_ready(req_tready), .q_full(q_full), .push(push), .push_data(push_data)
   );

   ghp_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(push_data),
      .full(q_full), .pop(pop), .head(head), .empty(q_empty)
   );

   ghp_back u_back (
      .clock(clock), .reset(reset), .head(head), .empty(q_empty), .pop(pop),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_rec(rec),
      .out_last(rsp_tlast)
   );

   assign rsp_tuser = rec.kind;
   assign rsp_tdata = {2'b00, rec.offset, rec.dims[3], rec.dims[2], rec.dims[1],
                       rec.dims[0], rec.dim_count, rec.arr_etype, rec.vword,
                       rec.vtype, rec.entry};

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// Header parser testbench
// Streams model file headers into the parser one byte at a time. Most headers
// are well formed with random content, and the rest carry bad fields, are cut
// short, or have junk after the end. A scoreboard predicts every record and
// checks each one as it leaves the block, under several register settings.
// ----------------------------------------------------------------------------
module tb_top;

   typedef enum logic [4:0] {
      PH_MAGIC, PH_VERSION, PH_NTENS, PH_NKV, PH_KEYLEN, PH_KEYCHARS, PH_VTYPE,
      PH_SCALAR, PH_STRLEN, PH_STRDATA, PH_ARRTYPE, PH_ARRCOUNT, PH_ARRSKIP,
      PH_ELEMLEN, PH_ELEMDATA, PH_TNAMELEN, PH_TNAMECHARS, PH_NDIMS, PH_DIM,
      PH_TTYPE, PH_TOFF
   } parse_phase_type;

   typedef struct {
      logic [2:0]  kind;
      logic        last;
      logic [9:0]  entry;
      logic [3:0]  vtype;
      logic [63:0] vword;
      logic [31:0] arr_etype;
      logic [31:0] dim_count;
      logic [63:0] dim[4];
      logic [63:0] offset;
   } header_rec_type;

   localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam int          CYCLE_LIMIT = 600000;

   class header_scoreboard;
      logic [31:0]     magic, ver_lo, ver_hi;
      parse_phase_type phase;
      logic [3:0]      field_count;
      logic [63:0]     field_shift, skip_left, array_left, kv_left, tensor_left;
      logic [63:0]     position, cur_types;
      logic [63:0]     dims[4];
      logic [9:0]      entry_counter;
      logic [31:0]     dims_left, tensor_kind;
      logic [7:0]      name_sent;
      logic            finished;
      header_rec_type  step_recs[$];
      header_rec_type  pending[$];
      int              errors;

      function new();
         magic  = ghp_pkg::MAGIC_RESET;
         ver_lo = ghp_pkg::VERSION_MIN_RESET;
         ver_hi = ghp_pkg::VERSION_MAX_RESET;
         errors = 0;
         clear_parse();
      endfunction

      function void configure(logic [1:0] idx, logic [31:0] value);
         case (idx)
            ghp_pkg::CSR_MAGIC:       magic  = value;
            ghp_pkg::CSR_VERSION_MIN: ver_lo = value;
            ghp_pkg::CSR_VERSION_MAX: ver_hi = value;
            default: ;
         endcase
      endfunction

      function void clear_parse();
         phase = PH_MAGIC;
         field_count = 0; field_shift = 0; skip_left = 0; array_left = 0;
         kv_left = 0; tensor_left = 0; entry_counter = 0; position = 0;
         cur_types = 0; dims_left = 0; name_sent = 0; tensor_kind = 0;
         finished = 0;
         foreach (dims[i]) dims[i] = 0;
      endfunction

      function header_rec_type open_rec(logic [2:0] kind);
         header_rec_type r;
         r.kind = kind; r.last = 0; r.entry = entry_counter; r.vtype = 0;
         r.vword = 0; r.arr_etype = 0; r.dim_count = 0; r.offset = 0;
         foreach (r.dim[i]) r.dim[i] = 0;
         return r;
      endfunction

      function void fail(logic [63:0] code);
         header_rec_type r;
         r = open_rec(ghp_pkg::KIND_ERROR);
         r.vword = code;
         step_recs.push_back(r);
         finished = 1;
      endfunction

      function void emit_done();
         header_rec_type r;
         r = open_rec(ghp_pkg::KIND_DONE);
         r.entry = 0;
         r.offset = (position + 64'd31) & ~64'd31;
         step_recs.push_back(r);
         finished = 1;
      endfunction

      function bit gather(logic [7:0] b, int width, output logic [63:0] v);
         field_shift |= 64'(b) << (8 * field_count[2:0]);
         field_count++;
         v = field_shift;
         if (field_count >= width) begin
            field_shift = 0;
            field_count = 0;
            return 1;
         end
         return 0;
      endfunction

      function void start_tensors();
         entry_counter = 0;
         if (tensor_left > 0) phase = PH_TNAMELEN;
         else emit_done();
      endfunction

      function void next_kv();
         kv_left--;
         entry_counter++;
         if (kv_left > 0) phase = PH_KEYLEN;
         else start_tensors();
      endfunction

      function void skip_done(parse_phase_type ph);
         case (ph)
            PH_KEYCHARS:   phase = PH_VTYPE;
            PH_TNAMECHARS: phase = PH_NDIMS;
            PH_ELEMDATA: begin
               array_left--;
               if (array_left > 0) phase = PH_ELEMLEN;
               else next_kv();
            end
            default: next_kv();
         endcase
      endfunction

      function void begin_skip(parse_phase_type ph, logic [63:0] n);
         if (n == 0) begin
            skip_done(ph);
         end else begin
            phase = ph;
            skip_left = n;
         end
      endfunction

      function void skip_byte();
         skip_left--;
         if (skip_left == 0) skip_done(phase);
      endfunction

      function void name_byte(logic [7:0] b, int limit, logic [3:0] code);
         header_rec_type r;
         if (name_sent < limit - 1) begin
            r = open_rec(ghp_pkg::KIND_NAME);
            r.vtype = code;
            r.vword = 64'(b);
            step_recs.push_back(r);
            name_sent++;
         end
         skip_byte();
      endfunction

      function logic [63:0] size_of(logic [31:0] t);
         case (t)
            0, 1, 7:   return 1;
            2, 3:      return 2;
            4, 5, 6:   return 4;
            8, 9:      return 0;
            10, 11, 12: return 8;
            default:   return 4;
         endcase
      endfunction

      function void take_byte(logic [7:0] b);
         logic [63:0] v, et, esz, total;
         logic [31:0] idx;
         logic [3:0]  t;
         header_rec_type r;
         case (phase)
            PH_MAGIC: if (gather(b, 4, v)) begin
               if (v[31:0] != magic) fail(ghp_pkg::ERR_BAD_MAGIC);
               else phase = PH_VERSION;
            end
            PH_VERSION: if (gather(b, 4, v)) begin
               if (v < 64'(ver_lo) || v > 64'(ver_hi)) fail(ghp_pkg::ERR_BAD_VERSION);
               else phase = PH_NTENS;
            end
            PH_NTENS: if (gather(b, 8, v)) begin
               tensor_left = v;
               phase = PH_NKV;
            end
            PH_NKV: if (gather(b, 8, v)) begin
               kv_left = v;
               if (kv_left > ghp_pkg::MAX_KV_ENTRIES_DEF ||
                   tensor_left > ghp_pkg::MAX_TENSOR_ENTRIES_DEF) begin
                  fail(ghp_pkg::ERR_TOO_MANY);
               end else begin
                  entry_counter = 0;
                  r = open_rec(ghp_pkg::KIND_COUNTS);
                  r.vword = kv_left;
                  r.offset = tensor_left;
                  step_recs.push_back(r);
                  if (kv_left > 0) phase = PH_KEYLEN; else start_tensors();
               end
            end
            PH_KEYLEN: if (gather(b, 8, v)) begin
               name_sent = 0;
               begin_skip(PH_KEYCHARS, v);
            end
            PH_KEYCHARS: name_byte(b, ghp_pkg::KEY_NAME_LEN_DEF, ghp_pkg::NAME_KEY);
            PH_VTYPE: if (gather(b, 4, v)) begin
               if (v > ghp_pkg::TYPE_LAST) begin
                  fail(ghp_pkg::ERR_BAD_TYPE);
               end else begin
                  cur_types = v << 32;
                  if (v == ghp_pkg::TYPE_STRING) phase = PH_STRLEN;
                  else if (v == ghp_pkg::TYPE_ARRAY) phase = PH_ARRTYPE;
                  else phase = PH_SCALAR;
               end
            end
            PH_SCALAR: begin
               t = cur_types[35:32];
               if (gather(b, int'(size_of(32'(t))), v)) begin
                  r = open_rec(ghp_pkg::KIND_KV);
                  r.vtype = t;
                  r.vword = v;
                  step_recs.push_back(r);
                  next_kv();
               end
            end
            PH_STRLEN: if (gather(b, 8, v)) begin
               r = open_rec(ghp_pkg::KIND_KV);
               r.vtype = 4'(ghp_pkg::TYPE_STRING);
               r.vword = v;
               r.offset = position;
               step_recs.push_back(r);
               begin_skip(PH_STRDATA, v);
            end
            PH_ARRTYPE: if (gather(b, 4, v)) begin
               cur_types = {32'(ghp_pkg::TYPE_ARRAY), v[31:0]};
               phase = PH_ARRCOUNT;
            end
            PH_ARRCOUNT: if (gather(b, 8, v)) begin
               et = {32'd0, cur_types[31:0]};
               r = open_rec(ghp_pkg::KIND_KV);
               r.vtype = 4'(ghp_pkg::TYPE_ARRAY);
               r.vword = v;
               r.arr_etype = et[31:0];
               r.offset = position;
               step_recs.push_back(r);
               if (et == ghp_pkg::TYPE_STRING) begin
                  if (v > 0) begin
                     array_left = v;
                     phase = PH_ELEMLEN;
                  end else begin
                     next_kv();
                  end
               end else begin
                  esz = size_of(et[31:0]);
                  total = (esz != 0 && v > ALL_ONES / esz) ? ALL_ONES : esz * v;
                  begin_skip(PH_ARRSKIP, total);
               end
            end
            PH_ELEMLEN: if (gather(b, 8, v)) begin_skip(PH_ELEMDATA, v);
            PH_TNAMELEN: if (gather(b, 8, v)) begin
               foreach (dims[i]) dims[i] = 0;
               name_sent = 0;
               begin_skip(PH_TNAMECHARS, v);
            end
            PH_TNAMECHARS: name_byte(b, ghp_pkg::TENSOR_NAME_LEN_DEF, ghp_pkg::NAME_TENSOR);
            PH_NDIMS: if (gather(b, 4, v)) begin
               cur_types = v;
               dims_left = v[31:0];
               phase = (v > 0) ? PH_DIM : PH_TTYPE;
            end
            PH_DIM: if (gather(b, 8, v)) begin
               idx = cur_types[31:0] - dims_left;
               if (idx < ghp_pkg::MAX_DIMS_DEF && idx < 4) dims[idx[1:0]] = v;
               dims_left--;
               if (dims_left == 0) phase = PH_TTYPE;
            end
            PH_TTYPE: if (gather(b, 4, v)) begin
               tensor_kind = v[31:0];
               phase = PH_TOFF;
            end
            PH_TOFF: if (gather(b, 8, v)) begin
               r = open_rec(ghp_pkg::KIND_TENSOR);
               r.vword = 64'(tensor_kind);
               r.dim_count = cur_types[31:0];
               foreach (dims[i]) r.dim[i] = dims[i];
               r.offset = v;
               step_recs.push_back(r);
               tensor_left--;
               entry_counter++;
               if (tensor_left > 0) phase = PH_TNAMELEN; else emit_done();
            end
            default: skip_byte();
         endcase
      endfunction

      function void note_request(logic [7:0] b, logic last);
         step_recs.delete();
         if (!finished) begin
            position++;
            take_byte(b);
         end
         if (last) begin
            if (!finished) fail(ghp_pkg::ERR_TRUNCATED);
            clear_parse();
         end
         if (step_recs.size() > 0) step_recs[step_recs.size() - 1].last = 1;
         foreach (step_recs[i]) pending.push_back(step_recs[i]);
      endfunction

      function void compare(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_record(logic [2:0] kind, logic last, logic [463:0] data);
         header_rec_type e;
         if (pending.size() == 0) begin
            $error("record: expected none, actual kind %0d", kind);
            errors++;
            return;
         end
         e = pending.pop_front();
         compare("rec_kind", 64'(e.kind), 64'(kind));
         compare("run_last", 64'(e.last), 64'(last));
         compare("entry_index", 64'(e.entry), 64'(data[9:0]));
         compare("value_type", 64'(e.vtype), 64'(data[13:10]));
         compare("value_word", e.vword, data[77:14]);
         compare("array_elem_type", 64'(e.arr_etype), 64'(data[109:78]));
         compare("dim_count", 64'(e.dim_count), 64'(data[141:110]));
         compare("dim_zero", e.dim[0], data[205:142]);
         compare("dim_one", e.dim[1], data[269:206]);
         compare("dim_two", e.dim[2], data[333:270]);
         compare("dim_three", e.dim[3], data[397:334]);
         compare("offset_word", e.offset, data[461:398]);
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         csr_we = 0;
   logic [1:0]   csr_index = '0;
   logic [31:0]  csr_wdata = '0;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;
   logic         req_tlast = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [463:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         rsp_tlast;

   header_scoreboard sb = new();
   logic [7:0]  frame[$];
   int          bytes_sent = 0;
   int          cycles = 0;
   bit          send_quiet = 0;
   bit          recv_quiet = 0;

   gguf_header_stream_parser dut (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic write_csr(logic [1:0] idx, logic [31:0] value);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.configure(idx, value);
      csr_we <= 0;
      @(posedge clock);
   endtask

   task automatic settle();
      while (sb.pending.size() > 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic send_request(logic [7:0] b, logic last);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= b;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_request(b, last);
      bytes_sent++;
   endtask

   task automatic send_frame();
      foreach (frame[i]) send_request(frame[i], i == frame.size() - 1);
      req_tvalid <= 0;
      frame.delete();
      @(posedge clock);
   endtask

   function automatic void put_le(logic [63:0] value, int n);
      for (int i = 0; i < n; i++) frame.push_back(value[8*i +: 8]);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic void put_name(int len);
      put_le(64'(len), 8);
      repeat (len) frame.push_back(8'($urandom));
   endfunction

   function automatic int name_len();
      return ($urandom_range(0, 19) == 0) ? $urandom_range(62, 70) : $urandom_range(0, 6);
   endfunction

   function automatic void put_kv(bit bad_type);
      logic [31:0] t, et;
      logic [63:0] cnt;
      put_name(name_len());
      if (bad_type) begin
         put_le(64'($urandom_range(13, 200)), 4);
         return;
      end
      t = $urandom_range(0, 12);
      put_le(64'(t), 4);
      if (t == ghp_pkg::TYPE_STRING) begin
         put_name($urandom_range(0, 5));
      end else if (t == ghp_pkg::TYPE_ARRAY) begin
         case ($urandom_range(0, 4))
            0: et = ghp_pkg::TYPE_STRING;
            1: et = $urandom_range(13, 32'hFFFF_FFFF);
            default: et = $urandom_range(0, 12);
         endcase
         cnt = $urandom_range(0, 4);
         put_le(64'(et), 4);
         put_le(cnt, 8);
         if (et == ghp_pkg::TYPE_STRING) begin
            repeat (cnt) put_name($urandom_range(0, 3));
         end else begin
            repeat (cnt * sb.size_of(et)) frame.push_back(8'($urandom));
         end
      end else begin
         put_le(rand64(), int'(sb.size_of(t)));
      end
   endfunction

   function automatic void put_tensor();
      int nd;
      put_name(name_len());
      nd = $urandom_range(0, 6);
      put_le(64'(nd), 4);
      repeat (nd) put_le(rand64(), 8);
      put_le(64'($urandom), 4);
      put_le(rand64(), 8);
   endfunction

   // Build one header; mostly well formed, sometimes broken in one way.
   function automatic void build_header();
      int flaw, nkv, nt, bad_kv, cut;
      logic [31:0] ver;
      flaw = $urandom_range(0, 15);
      nkv = $urandom_range(0, 3);
      nt = $urandom_range(0, 3);
      bad_kv = (flaw == 4 && nkv > 0) ? $urandom_range(0, nkv - 1) : -1;
      put_le(64'(flaw == 1 ? sb.magic ^ (32'd1 << $urandom_range(0, 31)) : sb.magic), 4);
      ver = $urandom_range(sb.ver_hi, sb.ver_lo);
      if (flaw == 2 && sb.ver_hi != 32'hFFFF_FFFF) ver = sb.ver_hi + 1;
      if (flaw == 2 && sb.ver_lo != 0 && $urandom_range(0, 1)) ver = sb.ver_lo - 1;
      put_le(64'(ver), 4);
      if (flaw == 3) begin
         if ($urandom_range(0, 1)) put_le(64'(nt), 8); else put_le(rand64() | 64'd2048, 8);
         put_le(64'($urandom_range(257, 300)), 8);
      end else begin
         put_le(64'(nt), 8);
         put_le(64'(nkv), 8);
      end
      for (int i = 0; i < nkv; i++) put_kv(i == bad_kv);
      if (flaw == 5) begin
         // this flaw adds no bytes, so the header stays well formed
         put_le(64'(nkv + 1), 0);
      end
      for (int i = 0; i < nt; i++) put_tensor();
      if (flaw == 6 && frame.size() > 1) begin
         cut = $urandom_range(1, frame.size() - 1);
         while (frame.size() > cut) void'(frame.pop_back());
      end
      if (flaw == 7) repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom));
   endfunction

   task automatic run_phase(int budget);
      int stop;
      stop = bytes_sent + budget;
      while (bytes_sent < stop) begin
         send_quiet = ($urandom_range(0, 5) == 0);
         recv_quiet = ($urandom_range(0, 5) == 0);
         build_header();
         send_frame();
      end
      send_quiet = 0;
      recv_quiet = 0;
   endtask

   initial begin
      int stall;
      wait (!reset);
      forever begin
         stall = recv_quiet ? 0 : $urandom_range(0, 13);
         if (stall > 0) begin
            rsp_tready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_record(rsp_tuser, rsp_tlast, rsp_tdata);
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: bad magic, low version, huge array count cut short
      put_le(64'h4655_4746, 4);
      send_frame();
      put_le(64'(ghp_pkg::MAGIC_RESET), 4);
      put_le(64'd1, 4);
      send_frame();
      put_le(64'(ghp_pkg::MAGIC_RESET), 4);
      put_le(64'd3, 4);
      put_le(64'd0, 8);
      put_le(64'd1, 8);
      put_name(1);
      put_le(64'(ghp_pkg::TYPE_ARRAY), 4);
      put_le(64'd10, 4);
      put_le(64'h2000_0000_0000_0001, 8);
      put_le(64'hFF, 2);
      send_frame();
      run_phase(180);
      settle();

      write_csr(ghp_pkg::CSR_MAGIC, $urandom);
      write_csr(ghp_pkg::CSR_VERSION_MIN, 32'd0);
      write_csr(ghp_pkg::CSR_VERSION_MAX, 32'hFFFF_FFFF);
      run_phase(180);
      settle();

      write_csr(ghp_pkg::CSR_VERSION_MIN, 32'hFFFF_FFFF);
      write_csr(ghp_pkg::CSR_MAGIC, 32'hFFFF_FFFF);
      run_phase(180);
      settle();

      write_csr(ghp_pkg::CSR_MAGIC, 32'd0);
      write_csr(ghp_pkg::CSR_VERSION_MIN, 32'd0);
      write_csr(ghp_pkg::CSR_VERSION_MAX, 32'd0);
      run_phase(180);

      while (sb.pending.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
